>>> src/assert_macros.svh
// assertion helpers, sampled on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true at a clock edge
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

>>> src/cvd_pkg.sv
package cvd_pkg;

  // fixed field widths of the item channels
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CNT_IN_W  = 16;
  localparam int unsigned PROP_W    = 17;
  localparam int unsigned RAND_W    = 32;
  localparam int unsigned RAND_HALF = RAND_W / 2;
  localparam int unsigned SEL_W     = 10;
  localparam int unsigned GENE_W    = 10;
  localparam int unsigned SCNT_W    = 16;

  // proportion of one in q16 and the rounding half
  localparam logic [PROP_W-1:0] Q16_ONE  = 17'h10000;
  localparam logic [PROP_W-1:0] Q16_HALF = 17'h08000;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_DRAW = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic load;
    logic tgt_mul;
    logic tgt_fin;
    logic draw_lo;
    logic draw_hi;
    logic draw_cmp;
    logic walk_rd;
    logic walk_step;
    logic credit;
    logic skip;
    logic read_rd;
    logic read_fin;
    logic resp_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_e  op;
    logic last;
    logic draw_ok;
    logic take;
    logic walk_more;
  } dp_status_t;

endpackage

>>> src/cvd_if.sv
// input word channel
interface cvd_in_if;
  import cvd_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [CNT_IN_W-1:0] count;
  logic                last_gene;
  logic [PROP_W-1:0]   proportion;
  logic [RAND_W-1:0]   random_fraction;
  logic [SEL_W-1:0]    gene_select;

  modport source (
    output valid, operation, count, last_gene, proportion, random_fraction, gene_select,
    input  ready
  );
  modport sink (
    input  valid, operation, count, last_gene, proportion, random_fraction, gene_select,
    output ready
  );
endinterface

// result word channel
interface cvd_out_if;
  import cvd_pkg::*;

  logic              valid;
  logic              ready;
  logic              done_res;
  logic              picked;
  logic [GENE_W-1:0] picked_gene;
  logic [SCNT_W-1:0] sampled_count;

  modport source (
    output valid, done_res, picked, picked_gene, sampled_count,
    input  ready
  );
  modport sink (
    input  valid, done_res, picked, picked_gene, sampled_count,
    output ready
  );
endinterface

>>> src/cvd_ram.sv
module cvd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/cvd_ctrl.sv
module cvd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  cvd_pkg::dp_status_t  status_i,
  output cvd_pkg::dp_cmd_t     cmd_o
);
  import cvd_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_DECODE    = 13'b0000000000010,
    S_LOAD      = 13'b0000000000100,
    S_TGT_MUL   = 13'b0000000001000,
    S_TGT_FIN   = 13'b0000000010000,
    S_DRAW_LO   = 13'b0000000100000,
    S_DRAW_HI   = 13'b0000001000000,
    S_DRAW_CMP  = 13'b0000010000000,
    S_WALK      = 13'b0000100000000,
    S_WALK_WAIT = 13'b0001000000000,
    S_READ      = 13'b0010000000000,
    S_READ_WAIT = 13'b0100000000000,
    S_RESP      = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.op)
          OP_LOAD: state_d = S_LOAD;
          OP_DRAW: state_d = status_i.draw_ok ? S_DRAW_LO : S_RESP;
          OP_READ: state_d = S_READ;
          OP_NONE: state_d = S_RESP;
        endcase
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = status_i.last ? S_TGT_MUL : S_RESP;
      end
      S_TGT_MUL: begin
        cmd_o.tgt_mul = 1'b1;
        state_d       = S_TGT_FIN;
      end
      S_TGT_FIN: begin
        cmd_o.tgt_fin = 1'b1;
        state_d       = S_RESP;
      end
      S_DRAW_LO: begin
        cmd_o.draw_lo = 1'b1;
        state_d       = S_DRAW_HI;
      end
      S_DRAW_HI: begin
        cmd_o.draw_hi = 1'b1;
        state_d       = S_DRAW_CMP;
      end
      S_DRAW_CMP: begin
        cmd_o.draw_cmp = 1'b1;
        state_d        = S_WALK;
      end
      S_WALK: begin
        priority if (!status_i.take) begin
          cmd_o.skip = 1'b1;
          state_d    = S_RESP;
        end else if (status_i.walk_more) begin
          cmd_o.walk_rd = 1'b1;
          state_d       = S_WALK_WAIT;
        end else begin
          cmd_o.credit = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_WALK_WAIT: begin
        cmd_o.walk_step = 1'b1;
        state_d         = S_WALK;
      end
      S_READ: begin
        cmd_o.read_rd = 1'b1;
        state_d       = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        cmd_o.read_fin = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.resp_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/cvd_datapath.sv
module cvd_datapath #(
  parameter int unsigned GENES      = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cvd_pkg::dp_cmd_t              cmd_i,
  output cvd_pkg::dp_status_t           status_o,
  input  logic [cvd_pkg::OP_W-1:0]      operation_i,
  input  logic [cvd_pkg::CNT_IN_W-1:0]  count_i,
  input  logic                          last_gene_i,
  input  logic [cvd_pkg::PROP_W-1:0]    proportion_i,
  input  logic [cvd_pkg::RAND_W-1:0]    random_fraction_i,
  input  logic [cvd_pkg::SEL_W-1:0]     gene_select_i,
  output logic                          done_res_o,
  output logic                          picked_o,
  output logic [cvd_pkg::GENE_W-1:0]    picked_gene_o,
  output logic [cvd_pkg::SCNT_W-1:0]    sampled_count_o
);
  import cvd_pkg::*;

  localparam int unsigned GW  = (GENES > 1) ? $clog2(GENES) : 1;
  localparam int unsigned LW  = GW + 1;
  localparam int unsigned TW  = COUNT_BITS + $clog2(GENES);
  localparam int unsigned SW  = (GW > SEL_W) ? GW : SEL_W;
  localparam int unsigned TPW = TW + PROP_W;
  localparam int unsigned HW  = TW + RAND_HALF;
  localparam int unsigned FW  = TW + RAND_W;

  // captured input word
  logic [OP_W-1:0]       op_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  last_q;
  logic [PROP_W-1:0]     prop_q;
  logic [RAND_W-1:0]     rand_q;
  logic [SEL_W-1:0]      sel_q;

  // column state
  logic                  loading_q, loading_d;
  logic                  ready_q, ready_d;
  logic [LW-1:0]         gl_q, gl_d;
  logic [TW-1:0]         total_q, total_d;
  logic [TW-1:0]         left_q, left_d;
  logic [TW-1:0]         cons_q, cons_d;
  logic [TW-1:0]         rem_q, rem_d;
  logic [TW-1:0]         cum_q, cum_d;
  logic [GW-1:0]         ptr_q, ptr_d;
  logic [COUNT_BITS-1:0] cur_q, cur_d;

  // arithmetic and result holding registers
  logic [TPW-1:0]        tprod_q;
  logic [HW-1:0]         plo_q, phi_q;
  logic                  take_q;
  logic                  picked_q;
  logic [GENE_W-1:0]     pgene_q;
  logic [SCNT_W-1:0]     samp_q;
  logic                  out_done_q, out_picked_q;
  logic [GENE_W-1:0]     out_gene_q;
  logic [SCNT_W-1:0]     out_samp_q;

  logic [LW-1:0]         gl_base;
  logic [TW-1:0]         tot_base;
  logic [TPW-1:0]        tgt_sum;
  logic [PROP_W-1:0]     prop_sat;
  logic [FW-1:0]         draw_prod;
  logic                  draw_ok;

  // memory ports
  logic                  in_we, in_re;
  logic [GW-1:0]         in_raddr;
  logic [COUNT_BITS-1:0] in_rdata;
  logic                  sm_we;
  logic [COUNT_BITS-1:0] sm_rdata;

  cvd_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (GENES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (in_we),
    .waddr_i (gl_base[GW-1:0]),
    .wdata_i (cnt_q),
    .re_i    (in_re),
    .raddr_i (in_raddr),
    .rdata_o (in_rdata)
  );

  // sampled counts of genes the pointer has passed; the current gene lives in cur_q
  cvd_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (GENES)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (sm_we),
    .waddr_i (ptr_q),
    .wdata_i (cur_q),
    .re_i    (cmd_i.read_rd),
    .raddr_i (GW'(sel_q)),
    .rdata_o (sm_rdata)
  );

  assign in_re    = cmd_i.tgt_mul | cmd_i.walk_rd;
  assign in_raddr = cmd_i.tgt_mul ? '0 : ptr_q + GW'(1);
  assign sm_we    = cmd_i.walk_step;

  // target rounding and draw comparison
  assign prop_sat  = (prop_q > Q16_ONE) ? Q16_ONE : prop_q;
  assign tgt_sum   = tprod_q + TPW'(Q16_HALF);
  assign draw_prod = FW'(plo_q) + (FW'(phi_q) << RAND_HALF);
  assign draw_ok   = ready_q && (rem_q != '0);

  // a new column starts from cleared counters
  assign gl_base  = loading_q ? gl_q : '0;
  assign tot_base = loading_q ? total_q : '0;

  // column state update
  always_comb begin
    loading_d = loading_q;
    ready_d   = ready_q;
    gl_d      = gl_q;
    total_d   = total_q;
    left_d    = left_q;
    cons_d    = cons_q;
    rem_d     = rem_q;
    cum_d     = cum_q;
    ptr_d     = ptr_q;
    cur_d     = cur_q;
    in_we     = 1'b0;
    if (cmd_i.load) begin
      if (!loading_q) begin
        ready_d = 1'b0;
        ptr_d   = '0;
        cur_d   = '0;
        rem_d   = '0;
        cons_d  = '0;
        left_d  = '0;
        cum_d   = '0;
      end
      loading_d = !last_q;
      gl_d      = gl_base;
      total_d   = tot_base;
      // genes beyond the store are dropped
      if (gl_base < LW'(GENES)) begin
        in_we   = 1'b1;
        gl_d    = gl_base + LW'(1);
        total_d = tot_base + TW'(cnt_q);
      end
    end
    if (cmd_i.tgt_fin) begin
      rem_d   = tgt_sum[TW+15:16];
      left_d  = total_q;
      cons_d  = '0;
      cum_d   = TW'(in_rdata);
      ptr_d   = '0;
      cur_d   = '0;
      ready_d = 1'b1;
    end
    if (cmd_i.walk_step) begin
      ptr_d = ptr_q + GW'(1);
      cur_d = '0;
      cum_d = cum_q + TW'(in_rdata);
    end
    if (cmd_i.credit) begin
      cur_d = cur_q + COUNT_BITS'(1);
      rem_d = rem_q - TW'(1);
    end
    if (cmd_i.credit || cmd_i.skip) begin
      cons_d = cons_q + TW'(1);
      left_d = left_q - TW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loading_q <= 1'b0;
      ready_q   <= 1'b0;
      gl_q      <= '0;
      total_q   <= '0;
      left_q    <= '0;
      cons_q    <= '0;
      rem_q     <= '0;
      cum_q     <= '0;
      ptr_q     <= '0;
      cur_q     <= '0;
    end else begin
      loading_q <= loading_d;
      ready_q   <= ready_d;
      gl_q      <= gl_d;
      total_q   <= total_d;
      left_q    <= left_d;
      cons_q    <= cons_d;
      rem_q     <= rem_d;
      cum_q     <= cum_d;
      ptr_q     <= ptr_d;
      cur_q     <= cur_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= operation_i;
      cnt_q    <= COUNT_BITS'(count_i);
      last_q   <= last_gene_i;
      prop_q   <= proportion_i;
      rand_q   <= random_fraction_i;
      sel_q    <= gene_select_i;
      picked_q <= 1'b0;
      pgene_q  <= '0;
      samp_q   <= '0;
    end
    if (cmd_i.tgt_mul) begin
      tprod_q <= TPW'(prop_sat) * TPW'(total_q);
    end
    // left * u in two half-width products
    if (cmd_i.draw_lo) begin
      plo_q <= HW'(left_q) * HW'(rand_q[RAND_HALF-1:0]);
    end
    if (cmd_i.draw_hi) begin
      phi_q <= HW'(left_q) * HW'(rand_q[RAND_W-1:RAND_HALF]);
    end
    if (cmd_i.draw_cmp) begin
      take_q <= draw_prod < {rem_q, {RAND_W{1'b0}}};
    end
    if (cmd_i.credit) begin
      picked_q <= 1'b1;
      pgene_q  <= GENE_W'(ptr_q);
    end
    // genes behind the pointer come from memory, the current one from cur_q, ahead of it are still zero
    if (cmd_i.read_fin) begin
      if (SW'(sel_q) < SW'(ptr_q)) begin
        samp_q <= SCNT_W'(sm_rdata);
      end else if (SW'(sel_q) == SW'(ptr_q)) begin
        samp_q <= SCNT_W'(cur_q);
      end else begin
        samp_q <= '0;
      end
    end
    if (cmd_i.resp_load) begin
      out_done_q   <= draw_ok ^ ready_q;
      out_picked_q <= picked_q;
      out_gene_q   <= pgene_q;
      out_samp_q   <= samp_q;
    end
  end

  assign status_o.op        = op_e'(op_q);
  assign status_o.last      = last_q;
  assign status_o.draw_ok   = draw_ok;
  assign status_o.take      = take_q;
  assign status_o.walk_more = (cum_q <= cons_q) && ((LW'(ptr_q) + LW'(1)) < gl_q);

  assign done_res_o      = out_done_q;
  assign picked_o        = out_picked_q;
  assign picked_gene_o   = out_gene_q;
  assign sampled_count_o = out_samp_q;

endmodule

>>> src/count_vector_downsampler.sv
// Downsamples one column of per-gene read counts without replacement by
// selection sampling. Load words bring the counts in gene order; the word
// marked last_gene also brings the Q16 keep proportion and fixes the total and
// the target. Each draw word considers the next read of the column and, if it
// is kept, credits it to the gene that holds it; read-out words return a
// gene's sampled count. One word is worked on at a time and every word gives
// exactly one result word, held in an output register so the next word can be
// taken while it waits. A draw is ignored when the column is not ready or
// already done; otherwise it compares and, if the read is kept, walks the
// gene pointer with one registered read of the count memory per step. The
// last load also computes the target; a read-out reads the sample memory.
// No clearing pass is needed when a new column starts: sampled counts are
// written back only as the gene pointer moves past a gene.
`include "assert_macros.svh"

module count_vector_downsampler #(
  parameter int unsigned GENES      = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cvd_in_if.sink     in_i,
  cvd_out_if.source  out_o
);
  import cvd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  cvd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // counters, memories and arithmetic
  cvd_datapath #(
    .GENES      (GENES),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .operation_i       (in_i.operation),
    .count_i           (in_i.count),
    .last_gene_i       (in_i.last_gene),
    .proportion_i      (in_i.proportion),
    .random_fraction_i (in_i.random_fraction),
    .gene_select_i     (in_i.gene_select),
    .done_res_o        (out_o.done_res),
    .picked_o          (out_o.picked),
    .picked_gene_o     (out_o.picked_gene),
    .sampled_count_o   (out_o.sampled_count)
  );

  // checks
  `ASSERT_CLK(a_busy_after_accept, in_i.valid && in_i.ready |=> !in_i.ready, "word taken while busy")
  `ASSERT_NEVER(a_result_overwrite, cmd.resp_load && out_o.valid && !out_o.ready, "result lost")
  `ASSERT_CLK(a_step_follows_read, cmd.walk_step |-> $past(cmd.walk_rd), "walk step without read")
  `ASSERT_NEVER(a_credit_when_done, cmd.credit && !status.draw_ok, "read credited after done")

endmodule
